// File: src/khct_pkg.sv
// Shared types, command codes and helpers for the keyed hit counter table.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package khct_pkg;

  localparam int unsigned ENTRIES_DEF   = 64;
  localparam int unsigned KEY_BYTES_DEF = 8;

  typedef enum logic [1:0] {
    CMD_HIT  = 2'd0,
    CMD_TOT  = 2'd1,
    CMD_MOD  = 2'd2,
    CMD_FREQ = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    OP_EQ = 3'd0,
    OP_GT = 3'd1,
    OP_GE = 3'd2,
    OP_LT = 3'd3,
    OP_LE = 3'd4,
    OP_NE = 3'd5
  } cmp_op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_DONE,
    S_OUT
  } state_t;

  // Probe that travels down the cell chain.
  typedef struct packed {
    logic        active;
    logic [63:0] key;
    logic        hit;
    logic        alloc;
    logic [31:0] now;
    logic        matched;
    logic        free_taken;
    logic        old_valid;
    logic [31:0] count;
    logic [31:0] first;
  } probe_t;

  // Upper-case and truncate a raw key.
  function automatic logic [63:0] norm_key(input logic [63:0] raw, input int unsigned nbytes);
    logic [63:0] o;
    logic        ended;
    logic [7:0]  b;
    o = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      b = raw[(7-i)*8 +: 8];
      if (i >= nbytes || b == 8'h00) ended = 1'b1;
      if (ended) b = 8'h00;
      else if (b >= 8'h61 && b <= 8'h7a) b = b - 8'h20;
      o[(7-i)*8 +: 8] = b;
    end
    return o;
  endfunction

  function automatic logic cmp_vals(input logic [31:0] a, input logic [31:0] b,
                                    input logic [2:0] op);
    logic r;
    case (op)
      OP_EQ:   r = (a == b);
      OP_GT:   r = (a > b);
      OP_GE:   r = (a >= b);
      OP_LT:   r = (a < b);
      OP_LE:   r = (a <= b);
      OP_NE:   r = (a != b);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/keyed_hit_counter_table_core.sv
// Top level of the keyed hit counter table: request handshake, sequencer, result register.
// Depends on khct_pkg, khct_chain and khct_div.
`default_nettype none
// One request at a time. The cycle after a request is accepted, a probe
// enters the chain of ENTRIES cells and walks it; a hit on a missing key
// walks it a second time to claim the lowest free cell. Modulo and
// frequency queries that divide then run a bit-serial 64-step divider.
// The result sits in an output register and the next request can be taken
// in the cycle after it is loaded, while it waits; a stalled result holds
// the sequencer in its last step.
module keyed_hit_counter_table_core #(
  parameter int unsigned ENTRIES   = khct_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BYTES = khct_pkg::KEY_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [63:0] key,
  input  wire logic [31:0] now_seconds,
  input  wire logic [31:0] arg_value,
  input  wire logic        test_mode,
  input  wire logic [2:0]  compare_op,
  input  wire logic [31:0] test_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      value,
  output logic             found,
  output logic [1:0]       status
);
  import khct_pkg::*;

  state_t      state, state_next;
  logic [1:0]  r_cmd;
  logic [63:0] r_key;
  logic [31:0] r_now, r_arg, r_tval;
  logic        r_tmode;
  logic [2:0]  r_op;
  logic        r_alloc;
  logic        r_found;
  logic [31:0] r_count, r_first;
  logic [31:0] r_iv;
  logic [63:0] prod;
  logic [31:0] res, res_next;
  logic [1:0]  r_status;

  probe_t pin, pout;
  logic   div_start, div_busy;
  logic [63:0] div_q;
  logic [31:0] div_r;
  logic [31:0] elapsed;
  logic        in_take;
  logic        launch;

  assign in_take = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign elapsed = (r_now >= r_first) ? r_now - r_first : 32'd0;
  assign prod    = {32'd0, r_count} * {32'd0, r_iv};

  // Drive probe into the chain for one cycle
  always_comb begin
    pin            = '0;
    pin.active     = launch;
    pin.key        = r_key;
    pin.hit        = (r_cmd == CMD_HIT) && !r_alloc;
    pin.alloc      = r_alloc;
    pin.now        = r_now;
  end

  khct_chain #(.ENTRIES(ENTRIES)) u_chain (.clk(clk), .rst(rst), .pin(pin), .pout(pout));

  khct_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend((r_cmd == CMD_MOD) ? {32'd0, r_count} : prod),
    .divisor((r_cmd == CMD_MOD) ? r_arg : elapsed),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  // Next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    res_next   = res;
    case (state)
      S_IDLE: if (in_take) begin
        state_next = S_SCAN;
        res_next   = '0;
      end
      S_SCAN: begin
        if (pout.active) begin
          if (!r_alloc) begin
            if ((r_cmd == CMD_HIT || r_cmd == CMD_TOT) && pout.matched)
              res_next = pout.count;
          end else begin
            res_next = pout.free_taken ? 32'd1 : 32'd0;
          end
          if (r_cmd == CMD_HIT) begin
            if (pout.matched || r_alloc) state_next = S_DONE;
            else state_next = S_SCAN;
          end else if (r_cmd == CMD_MOD && r_arg == 32'd0) state_next = S_DONE;
          else if (!pout.matched) state_next = S_DONE;
          else if (r_cmd == CMD_TOT) state_next = S_DONE;
          else state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (r_cmd == CMD_FREQ && elapsed < r_iv) begin
          res_next   = r_count;
          state_next = S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: if (!div_busy) begin
        res_next   = (r_cmd == CMD_MOD) ? div_r : div_q[31:0];
        state_next = S_DONE;
      end
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Request capture and scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      r_alloc <= 1'b0;
      launch  <= 1'b0;
    end else begin
      state <= state_next;
      res   <= res_next;
      // Launch a probe once the request fields are registered, and again for the alloc pass of a missed hit
      launch <= in_take ||
                (state == S_SCAN && pout.active && r_cmd == CMD_HIT &&
                 !pout.matched && !r_alloc);
      if (in_take) begin
        r_cmd   <= cmd;
        r_key   <= norm_key(key, KEY_BYTES);
        r_now   <= now_seconds;
        r_arg   <= arg_value;
        r_iv    <= (arg_value == 32'd0) ? 32'd1 : arg_value;
        r_tmode <= test_mode;
        r_op    <= compare_op;
        r_tval  <= test_value;
        r_alloc <= 1'b0;
        r_status <= ST_OK;
      end
      if (state == S_SCAN && pout.active) begin
        if (!r_alloc) begin
          r_found <= pout.matched;
          r_count <= pout.count;
          r_first <= pout.first;
          if (r_cmd == CMD_HIT && !pout.matched) r_alloc <= 1'b1;
          if (r_cmd == CMD_MOD && r_arg == 32'd0) r_status <= ST_DIV0;
        end else begin
          r_status <= pout.free_taken ? ST_OK : ST_FULL;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        found     <= r_found;
        status    <= r_status;
        if (r_cmd != CMD_HIT && r_tmode && r_status == ST_OK)
          value <= {31'd0, cmp_vals(res, r_tval, r_op)};
        else
          value <= res;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Track the multiply step for the check below
  logic mul_seen;
  always_ff @(posedge clk) begin
    if (rst) mul_seen <= 1'b0;
    else     mul_seen <= (state == S_MUL);
  end

  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_take |=> !in_ready) else $error("request taken while busy");
  a_div_after_mul: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_MUL) else $error("divider started outside sequence");
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE) else $error("result without completion");
  a_mul_once: assert property (@(posedge clk) disable iff (rst)
    mul_seen |-> state != S_MUL) else $error("multiply state repeated");
endmodule
`default_nettype wire

// File: src/khct_cell.sv
// One table entry: key, count and first-seen time, plus its valid bit.
// Depends on khct_pkg; passes the probe to the next cell each cycle.
`default_nettype none
module khct_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire khct_pkg::probe_t  pin,
  output khct_pkg::probe_t       pout
);
  import khct_pkg::*;

  logic        valid;
  logic [63:0] key;
  logic [31:0] count;
  logic [31:0] first;
  logic        match;
  logic        take;
  probe_t      pnext;

  assign match = pin.active && valid && key == pin.key;
  // Take this slot only when the whole chain had no match (alloc pass).
  assign take  = pin.active && pin.alloc && !valid && !pin.free_taken;

  // Hold entry, bump on hit, fill on alloc
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
      key   <= pin.key;
      count <= 32'd1;
      first <= pin.now;
    end else if (match && pin.hit && count != 32'hFFFF_FFFF) begin
      count <= count + 32'd1;
    end
  end

  // Merge this cell's answer into the passing probe
  always_comb begin
    pnext            = pin;
    pnext.free_taken = pin.free_taken | take;
    if (match) begin
      pnext.matched = 1'b1;
      pnext.count   = (pin.hit && count != 32'hFFFF_FFFF) ? count + 32'd1 : count;
      pnext.first   = first;
    end
  end

  // Advance probe
  always_ff @(posedge clk) begin
    if (rst) begin
      pout.active <= 1'b0;
    end else begin
      pout <= pnext;
    end
  end
endmodule
`default_nettype wire

// File: src/khct_chain.sv
// Row of table cells; a probe enters at cell 0 and leaves through the register of the last cell.
// Depends on khct_pkg and khct_cell.
`default_nettype none
module khct_chain #(
  parameter int unsigned ENTRIES = khct_pkg::ENTRIES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire khct_pkg::probe_t pin,
  output khct_pkg::probe_t      pout
);
  import khct_pkg::*;

  probe_t link [ENTRIES+1];

  assign link[0] = pin;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    khct_cell u_cell (.clk(clk), .rst(rst), .pin(link[g]), .pout(link[g+1]));
  end
  assign pout = link[ENTRIES];
endmodule
`default_nettype wire

// File: src/khct_div.sv
// Restoring divider, one quotient bit per cycle while busy, 64-bit dividend / 32-bit divisor.
// Depends on khct_pkg for nothing but the house import.
`default_nettype none
module khct_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic [63:0]      quotient,
  output logic [31:0]      remainder
);
  import khct_pkg::*;

  logic [6:0]  bitcnt;
  logic [32:0] rem;
  logic [63:0] quo;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem[31:0], quo[63]};
  assign trial   = shifted - {1'b0, divisor};

  // Shift in one dividend bit per cycle while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      bitcnt <= '0;
    end else if (start) begin
      busy   <= 1'b1;
      bitcnt <= 7'd64;
      rem    <= '0;
      quo    <= dividend;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial;
        quo <= {quo[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[62:0], 1'b0};
      end
      bitcnt <= bitcnt - 7'd1;
      if (bitcnt == 7'd1) busy <= 1'b0;
    end
  end

  assign quotient  = quo;
  assign remainder = rem[31:0];
endmodule
`default_nettype wire
